/* hw/rtl/ssrc_pkg.sv */
`default_nettype none

package ssrc_pkg;

    localparam int SLOTS_DEFAULT   = 32;
    localparam int ID_BITS_DEFAULT = 16;
    localparam int SLOT_OUT_W      = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_START  = 2'd2,
        CMD_READY  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/ssrc_cell.sv */
`default_nettype none

module ssrc_cell #(
    parameter int SLOTS    = ssrc_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS  = ssrc_pkg::ID_BITS_DEFAULT,
    parameter int CELL_IDX = 0
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic prev_valid,
    input  wire logic [2*$clog2(SLOTS)+3*$clog2(SLOTS+1)+ID_BITS+4-1:0] prev_probe,
    output logic      next_valid,
    output logic [2*$clog2(SLOTS)+3*$clog2(SLOTS+1)+ID_BITS+4-1:0] next_probe,
    input  wire logic [2*$clog2(SLOTS)+ID_BITS+5-1:0] cmt
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic [CNT_W-1:0]   used_count;
        logic               rdy_present;
        logic               rdy_free_found;
        logic [CNT_W-1:0]   rdy_free_idx_unused_pad;
        logic [CNT_W-1:0]   rdy_count;
    } probe_t;

    typedef struct packed {
        logic               en;
        logic               slot_wr;
        logic               slot_clr;
        logic               rdy_wr;
        logic               rdy_clr;
        logic [IDX_W-1:0]   slot_idx;
        logic [IDX_W-1:0]   rdy_idx;
        logic [ID_BITS-1:0] id;
    } commit_t;

    probe_t             p_in;
    probe_t             p_out;
    probe_t             probe_reg;
    logic               valid_reg;
    commit_t            c;
    logic [ID_BITS-1:0] slot_id_reg;
    logic               slot_used_reg;
    logic               slot_used_next;
    logic [ID_BITS-1:0] rdy_id_reg;
    logic               rdy_used_reg;
    logic               rdy_used_next;
    logic               slot_sel;
    logic               rdy_sel;

    assign p_in       = probe_t'(prev_probe);
    assign c          = commit_t'(cmt);
    assign next_valid = valid_reg;
    assign next_probe = probe_reg;

    // The ready-set free index travels in the spare field, zero-extended.
    always_comb
    begin
        p_out = p_in;
        if (slot_used_reg && (slot_id_reg == p_in.id) && !p_in.hit)
        begin
            p_out.hit     = 1'b1;
            p_out.hit_idx = MY_IDX;
        end
        if (!slot_used_reg && !p_in.free_found)
        begin
            p_out.free_found = 1'b1;
            p_out.free_idx   = MY_IDX;
        end
        p_out.used_count = p_in.used_count + CNT_W'(slot_used_reg);
        if (rdy_used_reg)
        begin
            p_out.rdy_count = p_in.rdy_count + CNT_W'(1);
            if (rdy_id_reg == p_in.id)
            begin
                p_out.rdy_present = 1'b1;
            end
        end
        else if (!p_in.rdy_free_found)
        begin
            p_out.rdy_free_found          = 1'b1;
            p_out.rdy_free_idx_unused_pad = CNT_W'(CELL_IDX);
        end
    end

    assign slot_sel = c.en && (c.slot_idx == MY_IDX);
    assign rdy_sel  = c.en && (c.rdy_idx == MY_IDX);

    always_comb
    begin
        slot_used_next = slot_used_reg;
        if (slot_sel && c.slot_wr)
        begin
            slot_used_next = 1'b1;
        end
        else if (slot_sel && c.slot_clr)
        begin
            slot_used_next = 1'b0;
        end
        rdy_used_next = rdy_used_reg;
        if (c.en && c.rdy_clr)
        begin
            rdy_used_next = 1'b0;
        end
        else if (rdy_sel && c.rdy_wr)
        begin
            rdy_used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            slot_used_reg <= 1'b0;
            rdy_used_reg  <= 1'b0;
        end
        else
        begin
            valid_reg     <= prev_valid;
            slot_used_reg <= slot_used_next;
            rdy_used_reg  <= rdy_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= p_out;
        if (slot_sel && c.slot_wr)
        begin
            slot_id_reg <= c.id;
        end
        if (rdy_sel && c.rdy_wr)
        begin
            rdy_id_reg <= c.id;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/session_slot_table_ready_check.sv */
`default_nettype none

// Session slot table with a ready check. Each slot lives in one cell of a chain; a request
// is taken only while the block is idle, and its client ID then walks the chain one cell per
// clock, collecting the lookup hit, the lowest free slot, the occupied count and the ready-set
// state. A final register captures what leaves the chain; a commit state then applies the change
// to the addressed cells and loads the output register, once any earlier result has been taken,
// and only then is the next request accepted. The result waits in its register, and the next
// request may walk the chain meanwhile, but its commit waits; no clearing pass follows reset.
module session_slot_table_ready_check #(
    parameter int SLOTS   = ssrc_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = ssrc_pkg::ID_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        command,
    input  wire logic [ID_BITS-1:0]                client_id,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ssrc_pkg::SLOT_OUT_W-1:0]        slot,
    output logic                                   ok,
    output logic                                   all_ready
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int PROBE_W = 2 * IDX_W + 3 * CNT_W + ID_BITS + 4;
    localparam int CMT_W   = 2 * IDX_W + ID_BITS + 5;
    localparam int OUT_W   = ssrc_pkg::SLOT_OUT_W;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic [CNT_W-1:0]   used_count;
        logic               rdy_present;
        logic               rdy_free_found;
        logic [CNT_W-1:0]   rdy_free_idx;
        logic [CNT_W-1:0]   rdy_count;
    } probe_t;

    typedef struct packed {
        logic               en;
        logic               slot_wr;
        logic               slot_clr;
        logic               rdy_wr;
        logic               rdy_clr;
        logic [IDX_W-1:0]   slot_idx;
        logic [IDX_W-1:0]   rdy_idx;
        logic [ID_BITS-1:0] id;
    } commit_t;

    ssrc_pkg::state_t   state_reg;
    ssrc_pkg::state_t   state_next;
    ssrc_pkg::cmd_t     cmd_reg;
    logic [ID_BITS-1:0] id_reg;
    probe_t             final_reg;
    logic               active_reg;
    logic               active_next;
    logic [CNT_W-1:0]   req_reg;
    logic [CNT_W-1:0]   req_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OUT_W-1:0]   slot_reg;
    logic [OUT_W-1:0]   slot_next;
    logic               ok_reg;
    logic               ok_next;
    logic               done_reg;
    logic               done_next;

    logic               accept;
    logic               chain_out;
    logic               commit_go;
    commit_t            cmt;
    probe_t             launch;
    logic [IDX_W-1:0]   res_idx;
    logic [IDX_W+OUT_W-1:0] slot_ext;
    logic               ins;
    logic [CNT_W-1:0]   cnt;

    logic [SLOTS:0]              chain_valid;
    logic [SLOTS:0][PROBE_W-1:0] chain_probe;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        launch    = '0;
        launch.id = client_id;
    end

    assign chain_valid[0] = accept;
    assign chain_probe[0] = launch;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ssrc_cell #(
            .SLOTS    (SLOTS),
            .ID_BITS  (ID_BITS),
            .CELL_IDX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_valid (chain_valid[g]),
            .prev_probe (chain_probe[g]),
            .next_valid (chain_valid[g+1]),
            .next_probe (chain_probe[g+1]),
            .cmt        (CMT_W'(cmt))
        );
    end

    assign chain_out = chain_valid[SLOTS];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssrc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ssrc_pkg::ST_SCAN;
                end
            end
            ssrc_pkg::ST_SCAN:
            begin
                if (chain_out)
                begin
                    state_next = ssrc_pkg::ST_COMMIT;
                end
            end
            ssrc_pkg::ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ssrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ssrc_pkg::ST_IDLE);
        commit_go = (state_reg == ssrc_pkg::ST_COMMIT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        cmt         = '0;
        cmt.en      = commit_go;
        cmt.id      = id_reg;
        cmt.rdy_idx = final_reg.rdy_free_idx[IDX_W-1:0];
        active_next = active_reg;
        req_next    = req_reg;
        ok_next     = 1'b0;
        done_next   = 1'b0;
        res_idx     = '0;
        ins         = 1'b0;
        cnt         = final_reg.rdy_count;
        case (cmd_reg)
            ssrc_pkg::CMD_ADD:
            begin
                ok_next      = !final_reg.hit && final_reg.free_found;
                res_idx      = final_reg.free_idx;
                cmt.slot_wr  = ok_next;
                cmt.slot_idx = final_reg.free_idx;
            end
            ssrc_pkg::CMD_REMOVE:
            begin
                ok_next      = final_reg.hit;
                res_idx      = final_reg.hit_idx;
                cmt.slot_clr = ok_next;
                cmt.slot_idx = final_reg.hit_idx;
            end
            ssrc_pkg::CMD_START:
            begin
                ok_next     = (final_reg.used_count != '0);
                cmt.rdy_clr = ok_next;
                if (ok_next)
                begin
                    active_next = 1'b1;
                    req_next    = final_reg.used_count;
                end
            end
            default:
            begin
                if (active_reg)
                begin
                    ins         = !final_reg.rdy_present && final_reg.rdy_free_found;
                    cnt         = final_reg.rdy_count + CNT_W'(ins);
                    ok_next     = ins;
                    cmt.rdy_wr  = ins;
                    done_next   = (cnt >= req_reg);
                    cmt.rdy_clr = done_next;
                    if (done_next)
                    begin
                        active_next = 1'b0;
                        req_next    = '0;
                    end
                end
            end
        endcase
        slot_ext  = {OUT_W'(0), res_idx};
        slot_next = (ok_next && ((cmd_reg == ssrc_pkg::CMD_ADD)
                                 || (cmd_reg == ssrc_pkg::CMD_REMOVE)))
                    ? slot_ext[OUT_W-1:0] : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssrc_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            req_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit_go)
            begin
                active_reg <= active_next;
                req_reg    <= req_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= ssrc_pkg::cmd_t'(command);
            id_reg  <= client_id;
        end
        if (chain_out)
        begin
            final_reg <= probe_t'(chain_probe[SLOTS]);
        end
        if (commit_go)
        begin
            slot_reg <= slot_next;
            ok_reg   <= ok_next;
            done_reg <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign ok        = ok_reg;
    assign all_ready = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/ssrc_checker.sv */
`default_nettype none

module ssrc_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [ssrc_pkg::SLOT_OUT_W-1:0] slot,
    input  wire logic                       ok,
    input  wire logic                       all_ready
);

    // A request keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block took a request while the previous one was still in the chain");

    a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (slot == '0))
        else $error("failed request reports a nonzero slot");

    a_slot_zero_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && all_ready) |-> (slot == '0))
        else $error("ready completion reports a nonzero slot");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(slot) && $stable(ok) && $stable(all_ready)))
        else $error("stalled result changed");

endmodule

bind session_slot_table_ready_check ssrc_checker u_ssrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot      (slot),
    .ok        (ok),
    .all_ready (all_ready)
);

`default_nettype wire

/* tb/sv/session_slot_table_ready_check_test.sv */
`timescale 1ns / 1ps

module session_slot_table_ready_check_test;

    localparam int SLOTS       = ssrc_pkg::SLOTS_DEFAULT;
    localparam int ID_W        = ssrc_pkg::ID_BITS_DEFAULT;
    localparam int OUT_W       = ssrc_pkg::SLOT_OUT_W;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [OUT_W-1:0] slot;
        logic             ok;
        logic             all_ready;
    } table_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       command;
    logic [ID_W-1:0]  client_id;
    logic             out_valid;
    logic             out_ready;
    logic [OUT_W-1:0] slot;
    logic             ok;
    logic             all_ready;

    // Shadow copy of the membership table and the ready set.
    logic [ID_W-1:0] member_id [SLOTS];
    bit              member_used [SLOTS];
    logic [ID_W-1:0] ready_id [SLOTS];
    bit              ready_used [SLOTS];
    bit              check_on;
    int              needed_count;

    table_result_t pending_results[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int requests_sent;
    int mismatches = 0;
    int idle_cycles;
    int adds_placed;
    int adds_refused_full;
    int removes_done;
    int checks_completed;

    session_slot_table_ready_check u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .client_id (client_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .slot      (slot),
        .ok        (ok),
        .all_ready (all_ready)
    );

    always #10 clk = ~clk;

    function automatic int find_member(logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (member_used[i] && member_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (member_used[i])
                n++;
        return n;
    endfunction

    function automatic table_result_t apply_command(ssrc_pkg::cmd_t c, logic [ID_W-1:0] id);
        table_result_t r;
        int            hit;
        int            free_at;
        int            filled;
        bit            present;
        r       = '0;
        hit     = find_member(id);
        free_at = -1;
        filled  = 0;
        present = 1'b0;
        case (c)
            ssrc_pkg::CMD_ADD:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!member_used[i] && free_at < 0)
                        free_at = i;
                if (hit < 0 && free_at >= 0)
                begin
                    member_used[free_at] = 1'b1;
                    member_id[free_at]   = id;
                    r.slot               = OUT_W'(free_at);
                    r.ok                 = 1'b1;
                    adds_placed++;
                end
                else if (hit < 0)
                begin
                    adds_refused_full++;
                end
            end
            ssrc_pkg::CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    member_used[hit] = 1'b0;
                    r.slot           = OUT_W'(hit);
                    r.ok             = 1'b1;
                    removes_done++;
                end
            end
            ssrc_pkg::CMD_START:
            begin
                filled = occupancy();
                if (filled > 0)
                begin
                    check_on     = 1'b1;
                    needed_count = filled;
                    for (int i = 0; i < SLOTS; i++)
                        ready_used[i] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            ssrc_pkg::CMD_READY:
            begin
                if (check_on)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (ready_used[i])
                        begin
                            filled++;
                            if (ready_id[i] == id)
                                present = 1'b1;
                        end
                        else if (free_at < 0)
                        begin
                            free_at = i;
                        end
                    end
                    if (!present && free_at >= 0)
                    begin
                        ready_used[free_at] = 1'b1;
                        ready_id[free_at]   = id;
                        filled++;
                        r.ok = 1'b1;
                    end
                    if (filled >= needed_count)
                    begin
                        r.all_ready = 1'b1;
                        for (int i = 0; i < SLOTS; i++)
                            ready_used[i] = 1'b0;
                        check_on     = 1'b0;
                        needed_count = 0;
                        checks_completed++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // When asked for while a check runs, only members still missing from the ready set are offered;
    // with no member to offer, an outside ID is returned.
    function automatic logic [ID_W-1:0] pick_member(bit want_unready);
        int cands [SLOTS];
        int n;
        bit seen;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (member_used[i])
            begin
                seen = 1'b0;
                if (want_unready && check_on)
                    for (int j = 0; j < SLOTS; j++)
                        if (ready_used[j] && ready_id[j] == member_id[i])
                            seen = 1'b1;
                if (!seen)
                begin
                    cands[n] = i;
                    n++;
                end
            end
        end
        if (n == 0)
            return ID_W'($urandom_range(0, 65535));
        return member_id[cands[$urandom_range(0, n - 1)]];
    endfunction

    task automatic send_request(input ssrc_pkg::cmd_t c, input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= c;
        client_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_command(c, id));
        requests_sent++;
    endtask

    task automatic test_directed();
        send_request(ssrc_pkg::CMD_READY, 16'h1234);
        send_request(ssrc_pkg::CMD_START, 16'h0000);
        send_request(ssrc_pkg::CMD_REMOVE, 16'hFFFF);
        send_request(ssrc_pkg::CMD_ADD, 16'h0000);
        send_request(ssrc_pkg::CMD_ADD, 16'hFFFF);
        send_request(ssrc_pkg::CMD_ADD, 16'hFFFF);
        send_request(ssrc_pkg::CMD_ADD, 16'h8001);
        send_request(ssrc_pkg::CMD_REMOVE, 16'h0000);
        send_request(ssrc_pkg::CMD_ADD, 16'h7FFE);
        send_request(ssrc_pkg::CMD_START, 16'hFFFF);
        send_request(ssrc_pkg::CMD_READY, 16'hFFFF);
        send_request(ssrc_pkg::CMD_READY, 16'hFFFF);
        send_request(ssrc_pkg::CMD_READY, 16'hA5A5);
        send_request(ssrc_pkg::CMD_REMOVE, 16'h8001);
        send_request(ssrc_pkg::CMD_READY, 16'h7FFE);
        send_request(ssrc_pkg::CMD_READY, 16'h7FFE);
        send_request(ssrc_pkg::CMD_START, 16'h5A5A);
        send_request(ssrc_pkg::CMD_READY, 16'h0000);
        send_request(ssrc_pkg::CMD_START, 16'h0000);
        send_request(ssrc_pkg::CMD_READY, 16'h0000);
        send_request(ssrc_pkg::CMD_READY, 16'hFFFF);
        send_request(ssrc_pkg::CMD_REMOVE, 16'h7FFE);
        send_request(ssrc_pkg::CMD_REMOVE, 16'hFFFF);
    endtask

    task automatic test_fill_and_drain();
        while (occupancy() < SLOTS)
            send_request(ssrc_pkg::CMD_ADD, ID_W'($urandom_range(0, 65535)));
        send_request(ssrc_pkg::CMD_ADD, ID_W'($urandom_range(0, 65535)));
        send_request(ssrc_pkg::CMD_ADD, pick_member(1'b0));
        send_request(ssrc_pkg::CMD_START, ID_W'($urandom_range(0, 65535)));
        while (check_on)
            send_request(ssrc_pkg::CMD_READY, pick_member($urandom_range(0, 3) != 0));
        while (occupancy() > 0)
            send_request(ssrc_pkg::CMD_REMOVE, pick_member(1'b0));
    endtask

    // Each session adds one to four clients, runs a ready check until it completes or 100 requests
    // have gone by, amid restarts, removals and outside IDs, then trims the table back down.
    task automatic run_session();
        int guard;
        repeat ($urandom_range(1, 4))
            send_request(ssrc_pkg::CMD_ADD,
                         $urandom_range(0, 4) == 0 ? pick_member(1'b0)
                                                   : ID_W'($urandom_range(0, 65535)));
        send_request(ssrc_pkg::CMD_START, ID_W'($urandom_range(0, 65535)));
        guard = 0;
        while (check_on && guard < 100)
        begin
            case ($urandom_range(0, 9))
                0:       send_request(ssrc_pkg::CMD_READY, ID_W'($urandom_range(0, 65535)));
                1:       send_request(ssrc_pkg::CMD_REMOVE, pick_member(1'b0));
                2:       send_request(ssrc_pkg::CMD_START, ID_W'($urandom_range(0, 65535)));
                3:       send_request(ssrc_pkg::CMD_READY, pick_member(1'b0));
                default: send_request(ssrc_pkg::CMD_READY, pick_member(1'b1));
            endcase
            guard++;
        end
        while (occupancy() > 0 && (occupancy() > 6 || $urandom_range(0, 2) == 0))
            send_request(ssrc_pkg::CMD_REMOVE,
                         $urandom_range(0, 7) == 0 ? ID_W'($urandom_range(0, 65535))
                                                   : pick_member(1'b0));
    endtask

    task automatic test_random_sessions(input int quota);
        int stop_at;
        stop_at = requests_sent + quota;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 20)
                send_request(ssrc_pkg::cmd_t'($urandom_range(0, 3)),
                             $urandom_range(0, 1) ? pick_member(1'b0)
                                                  : ID_W'($urandom_range(0, 65535)));
            else
                run_session();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: slot %0d ok %0b all_ready %0b",
                             slot, ok, all_ready);
            end
            else
            begin
                want = pending_results.pop_front();
                if (slot !== want.slot || ok !== want.ok || all_ready !== want.all_ready)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected slot %0d ok %0b all_ready %0b, ",
                                  "got slot %0d ok %0b all_ready %0b"},
                                 want.slot, want.ok, want.all_ready, slot, ok, all_ready);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no request moved for %0d cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        command            = ssrc_pkg::CMD_ADD;
        client_id          = '0;
        check_on           = 1'b0;
        needed_count       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        requests_sent      = 0;
        adds_placed        = 0;
        adds_refused_full  = 0;
        removes_done       = 0;
        checks_completed   = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            member_used[i] = 1'b0;
            ready_used[i]  = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_sessions(150);

        sender_idle_pct    = 88;
        receiver_stall_pct = 0;
        test_random_sessions(150);

        sender_idle_pct    = 0;
        receiver_stall_pct = 88;
        test_fill_and_drain();
        test_random_sessions(100);

        sender_idle_pct    = 15;
        receiver_stall_pct = 15;
        test_random_sessions(150);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("Ran %0d requests: %0d adds placed, %0d refused on a full table, %0d removes.",
                 requests_sent, adds_placed, adds_refused_full, removes_done);
        $display("Ready checks completed: %0d; result mismatches: %0d.",
                 checks_completed, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
